>>> sv/pvct_pkg.sv
// Shared types, constants and helpers for the page volatility counter table.
// Used by every module of the block except pvct_ram; depends on nothing.
`default_nettype none

package pvct_pkg;

    localparam int unsigned NODES           = 4;
    localparam int unsigned SLICES_PER_NODE = 16384;
    localparam int unsigned COUNT_BITS      = 3;
    localparam int unsigned ENTRIES         = NODES * SLICES_PER_NODE;
    localparam int unsigned IDX_W           = $clog2(ENTRIES);

    typedef logic [COUNT_BITS-1:0] count_t;
    typedef logic [IDX_W-1:0]      idx_t;

    localparam count_t COUNT_MAX = '1;
    localparam idx_t   LAST_IDX  = IDX_W'(ENTRIES - 1);

    typedef enum logic [2:0] {
        CMD_READ            = 3'd0,
        CMD_CLEAR           = 3'd1,
        CMD_ADD             = 3'd2,
        CMD_COPY_MARK       = 3'd3,
        CMD_SET_VOLATILE_IF = 3'd4,
        CMD_SET_SCAN_IF     = 3'd5,
        CMD_SCAN_CHECK      = 3'd6
    } cmd_e;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FETCH,
        ST_EXEC,
        ST_COPY_WR,
        ST_LOOKUP,
        ST_RESPOND
    } state_e;

    typedef struct packed {
        logic [2:0]  command;
        logic [1:0]  node;
        logic [13:0] slice;
        logic [1:0]  src_node;
        logic [13:0] src_slice;
        logic [2:0]  expected_count;
        logic [2:0]  new_count;
    } pvct_in_t;

    typedef struct packed {
        logic [2:0] volatile_count;
        logic [2:0] scan_level;
        logic       set_ok;
        logic       enqueue;
        logic       anomaly;
    } pvct_out_t;

    // Controller to datapath
    typedef struct packed {
        logic clear_wr;
        logic load_item;
        logic sel_src;
        logic exec_wr;
        logic copy_wr;
        logic load_rsp;
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic clear_last;
        logic is_copy;
        logic rsp_busy;
    } dp_status_t;

    function automatic count_t sat_inc(count_t v);
        return (v == COUNT_MAX) ? v : count_t'(v + count_t'(1));
    endfunction

endpackage

`default_nettype wire

>>> sv/pvct_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Stands alone; no package needed.
`default_nettype none

module pvct_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

>>> sv/pvct_ctrl.sv
// Sequencing state machine: clearing pass, then one command at a time.
// Depends on pvct_pkg for the state enum and the command/status structs.
`default_nettype none

module pvct_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cmd_valid,
    output logic                       cmd_stall,
    input  wire pvct_pkg::dp_status_t  status,
    output pvct_pkg::ctrl_cmd_t        ctl
);

    import pvct_pkg::*;

    state_e state_reg;
    state_e state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:   state_next = status.clear_last ? ST_IDLE : ST_CLEAR;
            ST_IDLE:    state_next = cmd_valid ? ST_FETCH : ST_IDLE;
            ST_FETCH:   state_next = ST_EXEC;
            ST_EXEC:    state_next = status.is_copy ? ST_COPY_WR : ST_LOOKUP;
            ST_COPY_WR: state_next = ST_LOOKUP;
            ST_LOOKUP:  state_next = ST_RESPOND;
            ST_RESPOND: state_next = status.rsp_busy ? ST_RESPOND : ST_IDLE;
            default:    state_next = ST_CLEAR;
        endcase
    end

    always_comb
    begin
        ctl       = '0;
        cmd_stall = 1'b1;
        case (state_reg)
            ST_CLEAR:
            begin
                ctl.clear_wr = 1'b1;
            end
            ST_IDLE:
            begin
                cmd_stall     = 1'b0;
                ctl.load_item = cmd_valid;
            end
            ST_FETCH:
            begin
                ctl.sel_src = status.is_copy;
            end
            ST_EXEC:
            begin
                ctl.exec_wr = 1'b1;
            end
            ST_COPY_WR:
            begin
                ctl.copy_wr = 1'b1;
            end
            ST_RESPOND:
            begin
                ctl.load_rsp = !status.rsp_busy;
            end
            default:
            begin
                ctl = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> sv/pvct_dp.sv
// Datapath: command register, both counter memories, update logic, clear
// counter and response register. Depends on pvct_pkg and pvct_ram.
`default_nettype none

module pvct_dp (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire pvct_pkg::pvct_in_t   cmd,
    output logic                      rsp_valid,
    input  wire logic                 rsp_stall,
    output pvct_pkg::pvct_out_t       rsp,
    input  wire pvct_pkg::ctrl_cmd_t  ctl,
    output pvct_pkg::dp_status_t      status
);

    import pvct_pkg::*;

    pvct_in_t  item_reg;
    pvct_out_t rsp_reg;
    logic      rsp_valid_reg;
    logic      rsp_valid_next;
    idx_t      clr_cnt_reg;
    count_t    copy_val_reg;
    logic      set_ok_reg;
    logic      enq_reg;
    logic      anom_reg;

    logic   tgt_ok;
    logic   src_ok;
    logic   rd_ok;
    idx_t   tgt_idx;
    idx_t   src_idx;
    idx_t   rd_addr;
    count_t vol_q;
    count_t scan_q;
    count_t vr;
    count_t sr;
    count_t newc;

    logic   vol_wr_en;
    idx_t   vol_wr_addr;
    count_t vol_wr_data;
    logic   scan_wr_en;
    idx_t   scan_wr_addr;
    count_t scan_wr_data;

    logic   set_ok_c;
    logic   enq_c;
    logic   anom_c;

    // Address decode; out-of-range entries read as zero and drop writes
    assign tgt_ok  = (32'(item_reg.node) < NODES) && (32'(item_reg.slice) < SLICES_PER_NODE);
    assign src_ok  = (32'(item_reg.src_node) < NODES)
                     && (32'(item_reg.src_slice) < SLICES_PER_NODE);
    assign tgt_idx = IDX_W'(IDX_W'(item_reg.node) * IDX_W'(SLICES_PER_NODE)
                     + IDX_W'(item_reg.slice));
    assign src_idx = IDX_W'(IDX_W'(item_reg.src_node) * IDX_W'(SLICES_PER_NODE)
                     + IDX_W'(item_reg.src_slice));
    assign rd_addr = ctl.sel_src ? src_idx : tgt_idx;

    assign rd_ok = (item_reg.command == CMD_COPY_MARK) ? src_ok : tgt_ok;
    assign vr    = rd_ok ? vol_q : '0;
    assign sr    = rd_ok ? scan_q : '0;
    assign newc  = item_reg.new_count[COUNT_BITS-1:0];

    pvct_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (ENTRIES)
    ) u_vol_ram (
        .clk     (clk),
        .wr_en   (vol_wr_en),
        .wr_addr (vol_wr_addr),
        .wr_data (vol_wr_data),
        .rd_addr (rd_addr),
        .rd_data (vol_q)
    );

    pvct_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (ENTRIES)
    ) u_scan_ram (
        .clk     (clk),
        .wr_en   (scan_wr_en),
        .wr_addr (scan_wr_addr),
        .wr_data (scan_wr_data),
        .rd_addr (rd_addr),
        .rd_data (scan_q)
    );

    // Write selection
    always_comb
    begin
        vol_wr_en    = 1'b0;
        vol_wr_addr  = tgt_idx;
        vol_wr_data  = '0;
        scan_wr_en   = 1'b0;
        scan_wr_addr = tgt_idx;
        scan_wr_data = '0;
        if (ctl.clear_wr)
        begin
            vol_wr_en    = 1'b1;
            vol_wr_addr  = clr_cnt_reg;
            scan_wr_en   = 1'b1;
            scan_wr_addr = clr_cnt_reg;
        end
        else if (ctl.exec_wr)
        begin
            case (item_reg.command)
                CMD_CLEAR:
                begin
                    vol_wr_en  = tgt_ok;
                    scan_wr_en = tgt_ok;
                end
                CMD_ADD:
                begin
                    vol_wr_en   = tgt_ok;
                    vol_wr_data = sat_inc(vr);
                end
                CMD_COPY_MARK:
                begin
                    vol_wr_en   = src_ok;
                    vol_wr_addr = src_idx;
                    vol_wr_data = sat_inc(vr);
                end
                CMD_SET_VOLATILE_IF:
                begin
                    vol_wr_en   = tgt_ok && (vr == item_reg.expected_count);
                    vol_wr_data = newc;
                end
                CMD_SET_SCAN_IF:
                begin
                    scan_wr_en   = tgt_ok && (sr == item_reg.expected_count);
                    scan_wr_data = newc;
                end
                CMD_SCAN_CHECK:
                begin
                    scan_wr_en   = tgt_ok && (vr != '0);
                    scan_wr_data = (sr == vr) ? '0 : sat_inc(sr);
                end
                default:
                begin
                    vol_wr_en  = 1'b0;
                    scan_wr_en = 1'b0;
                end
            endcase
        end
        else if (ctl.copy_wr)
        begin
            vol_wr_en   = tgt_ok;
            vol_wr_data = copy_val_reg;
        end
    end

    // Result flags
    always_comb
    begin
        set_ok_c = 1'b0;
        enq_c    = 1'b0;
        anom_c   = 1'b0;
        case (item_reg.command)
            CMD_SET_VOLATILE_IF: set_ok_c = (vr == item_reg.expected_count);
            CMD_SET_SCAN_IF:     set_ok_c = (sr == item_reg.expected_count);
            CMD_SCAN_CHECK:
            begin
                enq_c  = (vr == '0) || (sr == vr);
                anom_c = (vr != '0) && (sr > vr);
            end
            default:
            begin
                set_ok_c = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load_item)
        begin
            item_reg <= cmd;
        end
        if (ctl.exec_wr)
        begin
            copy_val_reg <= sat_inc(vr);
            set_ok_reg   <= set_ok_c;
            enq_reg      <= enq_c;
            anom_reg     <= anom_c;
        end
        if (ctl.load_rsp)
        begin
            rsp_reg.volatile_count <= 3'(tgt_ok ? vol_q : '0);
            rsp_reg.scan_level     <= 3'(tgt_ok ? scan_q : '0);
            rsp_reg.set_ok         <= set_ok_reg;
            rsp_reg.enqueue        <= enq_reg;
            rsp_reg.anomaly        <= anom_reg;
        end
    end

    assign rsp_valid_next = ctl.load_rsp ? 1'b1 : (rsp_stall ? rsp_valid_reg : 1'b0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
            clr_cnt_reg   <= '0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
            if (ctl.clear_wr)
            begin
                clr_cnt_reg <= idx_t'(clr_cnt_reg + idx_t'(1));
            end
        end
    end

    assign rsp_valid         = rsp_valid_reg;
    assign rsp               = rsp_reg;
    assign status.clear_last = (clr_cnt_reg == LAST_IDX);
    assign status.is_copy    = (item_reg.command == CMD_COPY_MARK);
    assign status.rsp_busy   = rsp_valid_reg && rsp_stall;

endmodule

`default_nettype wire

>>> sv/page_volatility_counter_table.sv
// Top level of the page volatility counter table.
// Depends on pvct_pkg, pvct_ctrl, pvct_dp (and through it pvct_ram).
//
//   channel  dir  handshake              payload
//   cmd      in   cmd_valid / cmd_stall  pvct_in_t  (command, target, source, counts)
//   rsp      out  rsp_valid / rsp_stall  pvct_out_t (both counts, set_ok, enqueue, anomaly)
//
// Each command runs as a read-modify-write on the two counter memories followed
// by a re-read of the target; copy-mark adds an extra write of the target, since
// each memory has a single write port. Commands are taken one at a time.
// After reset a clearing pass zeroes all ENTRIES (65536) locations, one per cycle;
// cmd_stall stays high until it finishes.
// A response held by rsp_stall waits in the output register; the next command is
// accepted meanwhile and holds in its last step until the register frees up.
`default_nettype none

module page_volatility_counter_table (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cmd_valid,
    output logic                     cmd_stall,
    input  wire pvct_pkg::pvct_in_t  cmd,
    output logic                     rsp_valid,
    input  wire logic                rsp_stall,
    output pvct_pkg::pvct_out_t      rsp
);

    import pvct_pkg::*;

    ctrl_cmd_t  ctl;
    dp_status_t status;

    // Sequence each command through fetch, update, re-read and respond
    pvct_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .status    (status),
        .ctl       (ctl)
    );

    // Hold the counters and build the response
    pvct_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .ctl       (ctl),
        .status    (status)
    );

    // An accepted command blocks the next one while it is in flight
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && !cmd_stall) |=> cmd_stall)
        else $error("command accepted back to back");

    // The clearing pass never overlaps command work
    a_clear_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.clear_wr |-> !(ctl.load_item || ctl.exec_wr || ctl.copy_wr || ctl.load_rsp))
        else $error("clearing pass overlaps a command");

    // A new response appears only when the controller loads one
    a_rsp_from_load: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(ctl.load_rsp))
        else $error("response without load");

    // Never overwrite a response that is still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.load_rsp |-> !(rsp_valid && rsp_stall))
        else $error("response overwritten while stalled");

endmodule

`default_nettype wire
